// File: sv/paob_pkg.sv
package paob_pkg;

	localparam int COORD_BITS       = 16;
	localparam int TERM_W           = COORD_BITS + 1;
	localparam int PROD_W           = 2 * TERM_W;
	localparam int AREA_W           = 45;
	localparam int COUNT_W          = 11;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MIN_AREA_COUNT   = 3;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [TERM_W-1:0]     term_t;

	// one classified vertex request, handed from front to back
	typedef struct packed {
		term_t                ys_step;
		term_t                xd_step;
		term_t                ys_close;
		term_t                xd_close;
		logic                 last;
		logic                 few;
		coord_t               x_min;
		coord_t               x_max;
		coord_t               y_min;
		coord_t               y_max;
		logic [COUNT_W-1:0]   count;
		logic                 ovf;
	} job_t;

endpackage

// File: sv/paob_front.sv
module paob_front import paob_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  coord_t vertex_x,
	input  coord_t vertex_y,
	input  logic   last_vertex,
	input  logic   vertex_valid,
	output logic   vertex_ready,
	input  logic   q_full,
	output logic   q_push,
	output job_t   q_job
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	coord_t           first_x_q, first_y_q, prev_x_q, prev_y_q;
	coord_t           x_min_q, x_max_q, y_min_q, y_max_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic             first;
	coord_t           fx, fy;
	coord_t           x_min_n, x_max_n, y_min_n, y_max_n;
	logic [CNT_W-1:0] count_n;
	logic             ovf_n;

	assign vertex_ready = !q_full;
	assign q_push       = vertex_valid && vertex_ready;

	always_comb begin
		first   = (count_q == '0);
		fx      = first ? vertex_x : first_x_q;
		fy      = first ? vertex_y : first_y_q;
		x_min_n = (first || vertex_x < x_min_q) ? vertex_x : x_min_q;
		x_max_n = (first || vertex_x > x_max_q) ? vertex_x : x_max_q;
		y_min_n = (first || vertex_y < y_min_q) ? vertex_y : y_min_q;
		y_max_n = (first || vertex_y > y_max_q) ? vertex_y : y_max_q;
		if (count_q < CNT_W'(MAX_VERTICES)) begin
			count_n = count_q + CNT_W'(1);
			ovf_n   = ovf_q;
		end else begin
			count_n = count_q;
			ovf_n   = 1'b1;
		end

		q_job.ys_step  = first ? '0 : TERM_W'(vertex_y) + TERM_W'(prev_y_q);
		q_job.xd_step  = first ? '0 : TERM_W'(vertex_x) - TERM_W'(prev_x_q);
		q_job.ys_close = last_vertex ? TERM_W'(fy) + TERM_W'(vertex_y) : '0;
		q_job.xd_close = last_vertex ? TERM_W'(fx) - TERM_W'(vertex_x) : '0;
		q_job.last     = last_vertex;
		q_job.few      = (count_n < CNT_W'(MIN_AREA_COUNT));
		q_job.x_min    = x_min_n;
		q_job.x_max    = x_max_n;
		q_job.y_min    = y_min_n;
		q_job.y_max    = y_max_n;
		q_job.count    = COUNT_W'(count_n);
		q_job.ovf      = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			x_min_q   <= '0;
			x_max_q   <= '0;
			y_min_q   <= '0;
			y_max_q   <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (q_push) begin
			if (last_vertex) begin
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q  <= '0;
				prev_y_q  <= '0;
				x_min_q   <= '0;
				x_max_q   <= '0;
				y_min_q   <= '0;
				y_max_q   <= '0;
				count_q   <= '0;
				ovf_q     <= 1'b0;
			end else begin
				first_x_q <= fx;
				first_y_q <= fy;
				prev_x_q  <= vertex_x;
				prev_y_q  <= vertex_y;
				x_min_q   <= x_min_n;
				x_max_q   <= x_max_n;
				y_min_q   <= y_min_n;
				y_max_q   <= y_max_n;
				count_q   <= count_n;
				ovf_q     <= ovf_n;
			end
		end
	end

endmodule

// File: sv/paob_queue.sv
module paob_queue import paob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

endmodule

// File: sv/paob_back.sv
module paob_back import paob_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  job_t                      q_job,
	output logic                      q_pop,
	output logic signed [AREA_W-1:0]  twice_area,
	output logic                      clockwise,
	output coord_t                    box_x_min,
	output coord_t                    box_x_max,
	output coord_t                    box_y_min,
	output coord_t                    box_y_max,
	output logic [COUNT_W-1:0]        vertex_count,
	output logic                      overflow,
	output logic                      result_valid,
	input  logic                      result_ready
);

	logic                      valid_s1;
	job_t                      job_s1;
	logic signed [PROD_W-1:0]  p_step_s1, p_close_s1;
	logic signed [AREA_W-1:0]  acc_q, acc_n, twice_n;
	logic                      adv;
	logic                      out_load;

	// s1 holds a last request only while the result register is full and not being read
	assign adv      = !valid_s1 || !job_s1.last || !result_valid || result_ready;
	assign q_pop    = adv;
	assign out_load = valid_s1 && job_s1.last && adv;
	assign acc_n    = acc_q + AREA_W'(p_step_s1) + AREA_W'(p_close_s1);
	assign twice_n  = job_s1.few ? '0 : -acc_n;

	always_ff @(posedge clk) begin
		if (adv && q_valid) begin
			job_s1     <= q_job;
			p_step_s1  <= q_job.ys_step * q_job.xd_step;
			p_close_s1 <= q_job.ys_close * q_job.xd_close;
		end
		if (out_load) begin
			twice_area   <= twice_n;
			clockwise    <= twice_n[AREA_W-1];
			box_x_min    <= job_s1.x_min;
			box_x_max    <= job_s1.x_max;
			box_y_min    <= job_s1.y_min;
			box_y_max    <= job_s1.y_max;
			vertex_count <= job_s1.count;
			overflow     <= job_s1.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			acc_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= q_valid;
			end
			if (valid_s1 && adv) begin
				acc_q <= job_s1.last ? '0 : acc_n;
			end
			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// File: sv/polygon_area_orientation_bbox_unit.sv
// Path: a request marked last goes through the queue, s1 and the result register.
// Throughput: one vertex per cycle unless the queue is full; the shoelace products
// are registered once and folded into a 45-bit accumulator in the next stage.
// A 2-entry queue separates the vertex front end from the multiply back end.
// Reset (arst_n low, asynchronous): polygon state, queue and result valid clear.
module polygon_area_orientation_bbox_unit import paob_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  coord_t                    vertex_x,
	input  coord_t                    vertex_y,
	input  logic                      last_vertex,
	input  logic                      vertex_valid,
	output logic                      vertex_ready,
	output logic signed [AREA_W-1:0]  twice_area,
	output logic                      clockwise,
	output coord_t                    box_x_min,
	output coord_t                    box_x_max,
	output coord_t                    box_y_min,
	output coord_t                    box_y_max,
	output logic [COUNT_W-1:0]        vertex_count,
	output logic                      overflow,
	output logic                      result_valid,
	input  logic                      result_ready
);

	logic q_full, q_push, q_valid, q_pop;
	job_t push_job, head_job;

	paob_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.vertex_valid(vertex_valid),
		.vertex_ready(vertex_ready),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	paob_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_job  (head_job)
	);

	paob_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (head_job),
		.q_pop       (q_pop),
		.twice_area  (twice_area),
		.clockwise   (clockwise),
		.box_x_min   (box_x_min),
		.box_x_max   (box_x_max),
		.box_y_min   (box_y_min),
		.box_y_max   (box_y_max),
		.vertex_count(vertex_count),
		.overflow    (overflow),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

// File: sv/paob_checker.sv
module paob_checker import paob_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic signed [AREA_W-1:0]  twice_area,
	input logic                      clockwise,
	input coord_t                    box_x_min,
	input coord_t                    box_x_max,
	input coord_t                    box_y_min,
	input coord_t                    box_y_max,
	input logic [COUNT_W-1:0]        vertex_count,
	input logic                      result_valid,
	input logic                      result_ready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(twice_area))
		else $error("result request dropped or changed while stalled");

	a_cw: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> clockwise == twice_area[AREA_W-1])
		else $error("clockwise flag disagrees with area sign");

	a_box: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> box_x_min <= box_x_max && box_y_min <= box_y_max)
		else $error("bounding box inverted");

	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && vertex_count != '0 && vertex_count < COUNT_W'(MIN_AREA_COUNT)
		|-> twice_area == '0 && !clockwise)
		else $error("degenerate polygon reported nonzero area");

endmodule

bind polygon_area_orientation_bbox_unit paob_checker u_paob_checker (.*);

// File: tb/tb_top.sv
module tb_top;
	import paob_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_VERTICES = 1600;
	localparam int OVERFLOW_RING   = MAX_VERTICES_DEF + 1;
	localparam int HOLD_CYCLES     = 300;

	typedef struct {
		logic [AREA_W-1:0]  area;
		logic               cw;
		coord_t             x_min;
		coord_t             x_max;
		coord_t             y_min;
		coord_t             y_max;
		logic [COUNT_W-1:0] cnt;
		logic               ovf;
	} poly_res_t;

	typedef struct {
		coord_t    x;
		coord_t    y;
		logic      last;
		bit        typed;
		poly_res_t want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	coord_t                   vertex_x;
	coord_t                   vertex_y;
	logic                     last_vertex;
	logic                     vertex_valid;
	logic                     vertex_ready;
	logic signed [AREA_W-1:0] twice_area;
	logic                     clockwise;
	coord_t                   box_x_min;
	coord_t                   box_x_max;
	coord_t                   box_y_min;
	coord_t                   box_y_max;
	logic [COUNT_W-1:0]       vertex_count;
	logic                     overflow;
	logic                     result_valid;
	logic                     result_ready;

	polygon_area_orientation_bbox_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.last_vertex  (last_vertex),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.twice_area   (twice_area),
		.clockwise    (clockwise),
		.box_x_min    (box_x_min),
		.box_x_max    (box_x_max),
		.box_y_min    (box_y_min),
		.box_y_max    (box_y_max),
		.vertex_count (vertex_count),
		.overflow     (overflow),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	poly_res_t poly_q[$];
	dir_row_t  dir_tab[$];
	poly_res_t blank;

	// ring tracking state
	coord_t            ring_first_x;
	coord_t            ring_first_y;
	coord_t            ring_prev_x;
	coord_t            ring_prev_y;
	logic [AREA_W-1:0] ring_sum;
	int                ring_count;
	bit                ring_ovf;
	coord_t            bx_min;
	coord_t            bx_max;
	coord_t            by_min;
	coord_t            by_max;

	int err_cnt;
	int results_seen;
	int vertices_sent;
	int rings_sent;
	int cw_rings;
	int ovf_rings;
	bit idle_on;
	int hold_req;
	int hold_left;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [AREA_W-1:0] pair_product(coord_t xa, coord_t ya,
			coord_t xb, coord_t yb);
		longint ys;
		longint xd;
		ys = longint'(ya) + longint'(yb);
		xd = longint'(xb) - longint'(xa);
		return AREA_W'(ys * xd);
	endfunction

	function automatic poly_res_t ring_result(longint area, coord_t x0, coord_t x1,
			coord_t y0, coord_t y1, int cnt);
		poly_res_t r;
		r.area  = AREA_W'(area);
		r.cw    = r.area[AREA_W-1];
		r.x_min = x0;
		r.x_max = x1;
		r.y_min = y0;
		r.y_max = y1;
		r.cnt   = COUNT_W'(cnt);
		r.ovf   = 1'b0;
		return r;
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'(16'sh8000);
			1: return coord_t'(16'sh7fff);
			2, 3, 4: return coord_t'($urandom_range(0, 1023) - 512);
			default: return coord_t'($urandom());
		endcase
	endfunction

	task automatic clear_ring();
		ring_first_x = '0;
		ring_first_y = '0;
		ring_prev_x  = '0;
		ring_prev_y  = '0;
		ring_sum     = '0;
		ring_count   = 0;
		ring_ovf     = 1'b0;
		bx_min       = '0;
		bx_max       = '0;
		by_min       = '0;
		by_max       = '0;
	endtask

	task automatic track_vertex(coord_t x, coord_t y, logic last);
		poly_res_t r;
		if (ring_count == 0) begin
			ring_first_x = x;
			ring_first_y = y;
			bx_min = x;
			bx_max = x;
			by_min = y;
			by_max = y;
		end else begin
			ring_sum = ring_sum + pair_product(ring_prev_x, ring_prev_y, x, y);
			if (x < bx_min) bx_min = x;
			if (x > bx_max) bx_max = x;
			if (y < by_min) by_min = y;
			if (y > by_max) by_max = y;
		end
		if (ring_count < MAX_VERTICES_DEF)
			ring_count++;
		else
			ring_ovf = 1'b1;
		ring_prev_x = x;
		ring_prev_y = y;
		if (last) begin
			ring_sum = ring_sum + pair_product(x, y, ring_first_x, ring_first_y);
			r.area  = (ring_count < MIN_AREA_COUNT) ? '0 : AREA_W'(-ring_sum);
			r.cw    = r.area[AREA_W-1];
			r.x_min = bx_min;
			r.x_max = bx_max;
			r.y_min = by_min;
			r.y_max = by_max;
			r.cnt   = COUNT_W'(ring_count);
			r.ovf   = ring_ovf;
			poly_q.push_back(r);
			rings_sent++;
			if (r.cw) cw_rings++;
			if (r.ovf) ovf_rings++;
			clear_ring();
		end
	endtask

	task automatic add_row(coord_t x, coord_t y, logic last, bit typed, poly_res_t want);
		dir_row_t row;
		row.x     = x;
		row.y     = y;
		row.last  = last;
		row.typed = typed;
		row.want  = want;
		dir_tab.push_back(row);
	endtask

	task automatic send_vertex(coord_t x, coord_t y, logic last);
		if (idle_on && $urandom_range(0, 99) < 13) begin
			vertex_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 13);
		end
		vertex_valid <= 1'b1;
		vertex_x     <= x;
		vertex_y     <= y;
		last_vertex  <= last;
		do @(posedge clk); while (!vertex_ready);
		vertices_sent++;
		track_vertex(x, y, last);
	endtask

	task automatic send_random_ring(int n);
		for (int k = 0; k < n; k++)
			send_vertex(pick_coord(), pick_coord(), k == n - 1);
	endtask

	task automatic drain_results();
		vertex_valid <= 1'b0;
		do @(posedge clk); while (poly_q.size() != 0);
	endtask

	task automatic note_mismatch(string what, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0d expected %0d",
			results_seen, what, got, want);
		err_cnt++;
	endtask

	task automatic check_polygon();
		poly_res_t want;
		results_seen++;
		if (poly_q.size() == 0) begin
			note_mismatch("result with no request pending", twice_area, 0);
			return;
		end
		want = poly_q.pop_front();
		if (twice_area !== want.area)
			note_mismatch("twice_area", twice_area, longint'($signed(want.area)));
		if (clockwise !== want.cw)
			note_mismatch("clockwise", clockwise, want.cw);
		if (box_x_min !== want.x_min)
			note_mismatch("box_x_min", box_x_min, want.x_min);
		if (box_x_max !== want.x_max)
			note_mismatch("box_x_max", box_x_max, want.x_max);
		if (box_y_min !== want.y_min)
			note_mismatch("box_y_min", box_y_min, want.y_min);
		if (box_y_max !== want.y_max)
			note_mismatch("box_y_max", box_y_max, want.y_max);
		if (vertex_count !== want.cnt)
			note_mismatch("vertex_count", vertex_count, want.cnt);
		if (overflow !== want.ovf)
			note_mismatch("overflow", overflow, want.ovf);
	endtask

	// result side: random stalls plus a long hold-off on request
	initial begin
		result_ready = 1'b0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				check_polygon();
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= (idle_on && $urandom_range(0, 99) < 13) ? 1'b0 : 1'b1;
			end
		end
	end

	initial begin
		int rand_sent;
		int n;
		int p;
		arst_n       = 1'b0;
		vertex_x     = '0;
		vertex_y     = '0;
		last_vertex  = 1'b0;
		vertex_valid = 1'b0;
		idle_on      = 1'b1;
		hold_req     = 0;
		err_cnt      = 0;
		results_seen = 0;
		vertices_sent = 0;
		rings_sent   = 0;
		cw_rings     = 0;
		ovf_rings    = 0;
		blank        = ring_result(0, 0, 0, 0, 0, 0);
		clear_ring();

		// single point
		add_row(100, -200, 1'b1, 1'b1, ring_result(0, 100, 100, -200, -200, 1));
		// two points at the coordinate extremes
		add_row(-32768, -32768, 1'b0, 1'b0, blank);
		add_row(32767, 32767, 1'b1, 1'b1, ring_result(0, -32768, 32767, -32768, 32767, 2));
		// 256-by-256 square, counterclockwise
		add_row(0, 0, 1'b0, 1'b0, blank);
		add_row(256, 0, 1'b0, 1'b0, blank);
		add_row(256, 256, 1'b0, 1'b0, blank);
		add_row(0, 256, 1'b1, 1'b1, ring_result(131072, 0, 256, 0, 256, 4));
		// 256-by-256 square, clockwise
		add_row(0, 0, 1'b0, 1'b0, blank);
		add_row(0, 256, 1'b0, 1'b0, blank);
		add_row(256, 256, 1'b0, 1'b0, blank);
		add_row(256, 0, 1'b1, 1'b1, ring_result(-131072, 0, 256, 0, 256, 4));
		// collinear triangle, zero area
		add_row(0, 0, 1'b0, 1'b0, blank);
		add_row(1, 1, 1'b0, 1'b0, blank);
		add_row(2, 2, 1'b1, 1'b1, ring_result(0, 0, 2, 0, 2, 3));
		// full-range triangle
		add_row(-32768, -32768, 1'b0, 1'b0, blank);
		add_row(32767, -32768, 1'b0, 1'b0, blank);
		add_row(32767, 32767, 1'b1, 1'b0, blank);
		// mixed-sign pentagon
		add_row(-32768, 0, 1'b0, 1'b0, blank);
		add_row(0, -32768, 1'b0, 1'b0, blank);
		add_row(32767, 0, 1'b0, 1'b0, blank);
		add_row(0, 32767, 1'b0, 1'b0, blank);
		add_row(-100, 200, 1'b1, 1'b0, blank);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_vertex(dir_tab[i].x, dir_tab[i].y, dir_tab[i].last);
			if (dir_tab[i].typed)
				poly_q[poly_q.size() - 1] = dir_tab[i].want;
		end
		drain_results();

		rand_sent = 0;
		p = 0;
		while (rand_sent < RANDOM_VERTICES) begin
			if (p == 10) idle_on = 1'b0;
			if (p == 25) idle_on = 1'b1;
			if (p == 30) begin
				// long result stall while single and two-point rings keep coming
				hold_req = HOLD_CYCLES;
				for (int k = 0; k < 40; k++) begin
					n = $urandom_range(1, 2);
					send_random_ring(n);
					rand_sent += n;
				end
			end
			if (p == 45) begin
				send_random_ring(OVERFLOW_RING);
				rand_sent += OVERFLOW_RING;
				drain_results();
			end
			if (p == 200) drain_results();
			n = $urandom_range(0, 99);
			if (n < 5)
				n = 1;
			else if (n < 10)
				n = 2;
			else if (n < 80)
				n = $urandom_range(3, 8);
			else
				n = $urandom_range(9, 40);
			send_random_ring(n);
			rand_sent += n;
			p++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Checked %0d polygons from %0d vertices: %0d clockwise, %0d overflowed.",
			results_seen, vertices_sent, cw_rings, ovf_rings);
		$display("Covered degenerate rings, extreme coordinates, idle gaps and backpressure.");
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
